// ===== rtl/ssu_pkg.sv =====
// Shared types and constants for the sorted set union block.
package ssu_pkg;

	// Width of one element value
	localparam int unsigned VALUE_W = 16;

	// Operation codes carried on the operation port
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// ===== rtl/ssu_store.sv =====
// Value store: single-port-write, registered-read synchronous memory.
module ssu_store
	import ssu_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered output
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ssu_ctrl.sv =====
// Load bookkeeping and repeated-minimum scan over the value store.
module ssu_ctrl
	import ssu_pkg::*;
#(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned AW       = 6,
	parameter int unsigned CW       = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         operation,
	input  logic [VALUE_W-1:0] value,
	output logic               busy,
	// store access
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [VALUE_W-1:0] mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  logic [VALUE_W-1:0] mem_rdata,
	// results
	output logic               strobe,
	output logic [VALUE_W-1:0] element,
	output logic               last,
	output logic               none,
	output logic               overflow
);

	state_t state_q, state_d;

	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [CW-1:0]      ridx_q;
	logic               rd_s1;
	logic               best_valid_q;
	logic [VALUE_W-1:0] best_q;
	logic               pend_valid_q;
	logic [VALUE_W-1:0] pend_q;
	logic               strobe_q;
	logic [VALUE_W-1:0] element_q;
	logic               last_q;
	logic               none_q;
	logic               overflow_q;

	logic accept, is_load, is_finish, has_room;
	logic load_ok, load_drop, finish_empty, finish_run;
	logic issue, pass_end, qual, run_done;

	// Decode and scan control
	always_comb begin
		busy         = (state_q == ST_SCAN);
		accept       = start && !busy;
		is_load      = operation inside {OP_LOAD_A, OP_LOAD_B};
		is_finish    = (operation == OP_FINISH);
		has_room     = (count_q < CW'(CAPACITY));
		load_ok      = accept && is_load && has_room;
		load_drop    = accept && is_load && !has_room;
		finish_empty = accept && is_finish && (count_q == '0);
		finish_run   = accept && is_finish && (count_q != '0);
		issue        = busy && (ridx_q != count_q);
		pass_end     = busy && (ridx_q == count_q) && !rd_s1;
		// candidate: above the value already taken and below the best so far
		qual         = rd_s1 && (!pend_valid_q || (mem_rdata > pend_q)) &&
			(!best_valid_q || (mem_rdata < best_q));
		run_done     = pass_end && !best_valid_q;

		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (finish_run) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (run_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Loads go in only while idle, reads happen only while scanning: no overlap
	assign mem_we    = load_ok;
	assign mem_waddr = count_q[AW-1:0];
	assign mem_wdata = value;
	assign mem_re    = issue;
	assign mem_raddr = ridx_q[AW-1:0];

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			ridx_q       <= '0;
			rd_s1        <= 1'b0;
			best_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_s1    <= issue;
			strobe_q <= finish_empty || (pass_end && pend_valid_q);

			if (load_ok) count_q <= count_q + CW'(1);
			else if (run_done) count_q <= '0;

			if (load_drop) ovf_q <= 1'b1;
			else if (finish_empty || run_done) ovf_q <= 1'b0;

			if (finish_run || (pass_end && best_valid_q)) ridx_q <= '0;
			else if (issue) ridx_q <= ridx_q + CW'(1);

			if (finish_run || pass_end) best_valid_q <= 1'b0;
			else if (qual) best_valid_q <= 1'b1;

			if (finish_run) pend_valid_q <= 1'b0;
			else if (pass_end && best_valid_q) pend_valid_q <= 1'b1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (qual) best_q <= mem_rdata;
		if (pass_end && best_valid_q) pend_q <= best_q;
		if (finish_empty) begin
			element_q  <= '0;
			last_q     <= 1'b1;
			none_q     <= 1'b1;
			overflow_q <= ovf_q;
		end else if (pass_end) begin
			// held value goes out; last when this pass found nothing larger
			element_q  <= pend_q;
			last_q     <= !best_valid_q;
			none_q     <= 1'b0;
			overflow_q <= ovf_q;
		end
	end

	assign strobe   = strobe_q;
	assign element  = element_q;
	assign last     = last_q;
	assign none     = none_q;
	assign overflow = overflow_q;

endmodule

// ===== rtl/sorted_set_union.sv =====
// Sorted set union top level: value store plus scan controller.
// Loads (operation 0 or 1) never raise busy; a load into a full store is
// dropped and flags overflow. A finish emits each distinct stored value
// once in ascending order, one strobe per result, last marked; an empty
// store gives one result with none set, in the cycle after the finish,
// without busy. Results cannot be held off by the receiver. The union is
// found by repeated minimum search: each pass reads all n stored entries
// through the single memory read port, and a run of d distinct values
// takes d + 1 passes with busy high; the store and overflow flag are clear
// when busy falls, together with the last result.
module sorted_set_union
	import ssu_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [VALUE_W-1:0] value,
	output logic               strobe,
	output logic [VALUE_W-1:0] element,
	output logic               last,
	output logic               none,
	output logic               overflow
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [VALUE_W-1:0] mem_rdata;

	// Value memory
	ssu_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Controller
	ssu_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.value     (value),
		.busy      (busy),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.strobe    (strobe),
		.element   (element),
		.last      (last),
		.none      (none),
		.overflow  (overflow)
	);

endmodule

// ===== rtl/ssu_checker.sv =====
// Port-level checker for the sorted set union block, with its bind.
module ssu_checker
	import ssu_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         operation,
	input logic               strobe,
	input logic [VALUE_W-1:0] element,
	input logic               last,
	input logic               none
);

	// Empty-union result is marked last and carries a zero element
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && none |-> last && (element == '0))
		else $error("none result not marked last or element nonzero");

	// More results pending means the run is still in progress
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result while not busy");

	// The final result ends the run
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("final result while still busy");

	// A run starts only from an accepted finish
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(operation) == OP_FINISH)
		else $error("busy rose without an accepted finish");

	// Back-to-back results after a non-final one must strictly ascend
	a_ascend: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last ##1 strobe |-> element > $past(element))
		else $error("results not strictly ascending");

endmodule

bind sorted_set_union ssu_checker u_ssu_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted set union block.
`timescale 1ns / 1ps

module testbench;
	import ssu_pkg::*;

	localparam int          CAP       = 64;
	localparam int          LIMIT     = 1000000;
	localparam logic [1:0]  OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [VALUE_W-1:0] element;
		logic               last;
		logic               none;
		logic               overflow;
	} union_out_t;

	// Predicts the union runs and checks each emitted element in order
	class union_board;
		logic [VALUE_W-1:0] held[CAP];
		int                 held_n;
		bit                 dropped;
		union_out_t         due[$];
		int                 mismatches;

		function int pending();
			return due.size();
		endfunction

		function void take_item(logic [1:0] op, logic [VALUE_W-1:0] val);
			logic [VALUE_W-1:0] sorted[CAP];
			logic [VALUE_W-1:0] key;
			union_out_t         r;
			int                 i;
			int                 j;
			if (op == OP_LOAD_A || op == OP_LOAD_B) begin
				if (held_n < CAP) begin
					held[held_n] = val;
					held_n++;
				end else begin
					dropped = 1;
				end
			end else if (op == OP_FINISH) begin
				if (held_n == 0) begin
					r = '{element: '0, last: 1'b1, none: 1'b1, overflow: dropped};
					due.push_back(r);
				end else begin
					// insertion sort of the held values
					for (i = 0; i < held_n; i++) begin
						key = held[i];
						j = i;
						while (j > 0 && sorted[j-1] > key) begin
							sorted[j] = sorted[j-1];
							j--;
						end
						sorted[j] = key;
					end
					// first copy of each value; the largest one closes the run
					for (i = 0; i < held_n; i++) begin
						if (i == 0 || sorted[i] != sorted[i-1]) begin
							r.element  = sorted[i];
							r.last     = (sorted[i] == sorted[held_n-1]);
							r.none     = 1'b0;
							r.overflow = dropped;
							due.push_back(r);
						end
					end
				end
				held_n  = 0;
				dropped = 0;
			end
		endfunction

		function void check_element(logic [VALUE_W-1:0] el, logic lst, logic nne,
				logic ovf);
			union_out_t want;
			union_out_t got;
			got = '{element: el, last: lst, none: nne, overflow: ovf};
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: element %h last %b none %b overflow %b",
						el, lst, nne, ovf);
			end else begin
				want = due.pop_front();
				// element carries no meaning on an empty union
				if (want.none === 1'b1)
					got.element = want.element;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp el %h last %b none %b ovf %b, ",
							"got el %h last %b none %b ovf %b"},
							want.element, want.last, want.none, want.overflow,
							el, lst, nne, ovf);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         operation;
	logic [VALUE_W-1:0] value;
	logic               strobe;
	logic [VALUE_W-1:0] element;
	logic               last;
	logic               none;
	logic               overflow;

	union_board board;
	int         accepted_cnt = 0;
	int         cycles       = 0;
	int         idle_pct     = 0;

	sorted_set_union #(.CAPACITY(CAP)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.value     (value),
		.strobe    (strobe),
		.element   (element),
		.last      (last),
		.none      (none),
		.overflow  (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sample handshakes and results at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				board.check_element(element, last, none, overflow);
			if (start && !busy) begin
				board.take_item(operation, value);
				accepted_cnt++;
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Present one item from a falling edge and hold it until accepted
	task automatic send_item(input logic [1:0] op, input logic [VALUE_W-1:0] val);
		int seen;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			operation = 2'($urandom);
			value = VALUE_W'($urandom);
			@(negedge clk);
		end
		start = 1'b1;
		operation = op;
		value = val;
		seen = accepted_cnt;
		do @(negedge clk); while (accepted_cnt == seen);
	endtask

	// Random load sets, each closed by a finish, with some ignored codes mixed in
	task automatic run_sets(input int goal);
		int                 sent;
		int                 sets;
		int                 len;
		int                 pick;
		bit                 narrow;
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] v;
		sent = 0;
		sets = 0;
		while (sent < goal) begin
			pick = $urandom_range(99);
			if (sets == 1)
				len = CAP + $urandom_range(1, 4);
			else if (pick < 78)
				len = $urandom_range(0, 10);
			else if (pick < 95)
				len = $urandom_range(11, 40);
			else
				len = $urandom_range(CAP - 2, CAP + 6);
			// narrow sets cluster values to force duplicates
			narrow = ($urandom_range(1) == 0);
			base = VALUE_W'($urandom);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(19) == 0)
					send_item(OP_UNUSED, VALUE_W'($urandom));
				v = narrow ? VALUE_W'(base + $urandom_range(0, 15)) : VALUE_W'($urandom);
				send_item($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A, v);
				sent++;
			end
			if ($urandom_range(19) == 0)
				send_item(OP_UNUSED, VALUE_W'($urandom));
			send_item(OP_FINISH, VALUE_W'($urandom));
			sent++;
			sets++;
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_LOAD_A;
		value = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty unions, extremes, ignored code, duplicates
		idle_pct = 0;
		send_item(OP_FINISH, 16'h0000);
		send_item(OP_FINISH, 16'hFFFF);
		send_item(OP_LOAD_A, 16'hFFFF);
		send_item(OP_LOAD_B, 16'h0000);
		send_item(OP_UNUSED, 16'h1234);
		send_item(OP_LOAD_A, 16'h0000);
		send_item(OP_LOAD_B, 16'hFFFF);
		send_item(OP_LOAD_A, 16'h8000);
		send_item(OP_LOAD_B, 16'h7FFF);
		send_item(OP_FINISH, 16'h5A5A);
		send_item(OP_LOAD_A, 16'h0007);
		send_item(OP_LOAD_A, 16'h0007);
		send_item(OP_LOAD_B, 16'h0007);
		send_item(OP_FINISH, 16'h0000);
		send_item(OP_LOAD_B, 16'h0001);
		send_item(OP_LOAD_B, 16'h0002);
		send_item(OP_FINISH, 16'h0000);
		send_item(OP_LOAD_A, 16'hAAAA);
		send_item(OP_LOAD_A, 16'h5555);
		send_item(OP_FINISH, 16'h0000);

		// Random phases: light sender gaps, heavy gaps, back to back
		idle_pct = 13;
		run_sets(75);
		idle_pct = 74;
		run_sets(75);
		idle_pct = 0;
		run_sets(75);

		start = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);

		if (board.mismatches == 0 && board.pending() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
